/* rtl/core/rpqd_pkg.sv */
// Shared types and codes for the per-worker ready queue dispatcher.
// Holds the controller state encoding, status and mode codes and the fixed port widths.
// No dependencies.
`default_nettype none

package rpqd_pkg;

    // Fixed widths of the item, result and configuration fields.
    localparam int HANDLE_W   = 16;
    localparam int WID_W      = 3;
    localparam int WCOUNT_W   = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REVERSED = 2'd3;

    // Item operation codes.
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BIND_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 1'd1;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_ENQ      = 7'b0000010,
        S_ENQ_END  = 7'b0000100,
        S_DQ_RD    = 7'b0001000,
        S_DQ_PTR   = 7'b0010000,
        S_DQ_DATA  = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/rpqd_store_ram.sv */
// Handle store of the dispatcher: all queue rings side by side in one array.
// Single write port and one registered read port; no dependencies.
`default_nettype none

module rpqd_store_ram #(
    parameter int DEPTH     = 512,
    parameter int ADDR_BITS = 9,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/rpqd_ptr_table.sv */
// Per-queue pointer table (head, tail and fill count packed in one word).
// Registered read with a one-entry bypass for a write to the entry being read,
// and a valid bit per entry so that unwritten entries read as zero. No dependencies.
`default_nettype none

module rpqd_ptr_table #(
    parameter int ENTRIES   = 8,
    parameter int ADDR_BITS = 3,
    parameter int DATA_BITS = 19
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    logic [DATA_BITS-1:0] rd_word_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic                 fwd_en_reg;
    logic [ADDR_BITS-1:0] fwd_addr_reg;
    logic [DATA_BITS-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg  <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        rd_addr_reg  <= rd_addr;
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fwd_en_reg <= 1'b0;
        end
        else
        begin
            fwd_en_reg <= wr_en;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // A write in the same cycle as the read is missed by the array; take it from the bypass.
    assign rd_data = (fwd_en_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg : rd_word_reg;

endmodule

`default_nettype wire

/* rtl/core/per_worker_ready_queue_dispatch_core.sv */
// Per-worker ready queue dispatcher: one ring FIFO of task handles per worker queue.
// Usage:
//   Items enter on in_valid/in_stall and results leave on out_valid/out_stall; a transfer
//   happens on a clock edge with valid high and stall low. Every item gives one result.
//   An enqueue item pushes first_handle..last_handle, dealt round-robin over the worker
//   queues in bound mode or all into queue 0 otherwise. A dequeue item pops one handle.
//   The pointer table read-modify-write cycle sets the pace: an enqueue pushes one handle
//   per cycle, a dequeue steps through S_DQ_RD, S_DQ_PTR and S_DQ_DATA (leaving out
//   S_DQ_DATA when the queue is empty), and a reversed range goes from transfer in straight
//   to S_DONE. One item is worked on at a time; in_stall is high while it is in progress.
//   A finished result sits in the output register, so the next item can be taken while
//   the receiver holds out_stall; a second result waits inside until the register frees.
//   Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle;
//   the block does not enforce this. Reset clears the controller, the configuration
//   (shared mode, one worker) and the pointer table valid bits, so all queues start empty
//   at once with no clearing pass. Handle store contents are undefined until written.
// Depends on rpqd_pkg, rpqd_ptr_table and rpqd_store_ram.
`default_nettype none

module per_worker_ready_queue_dispatch_core #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rpqd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rpqd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                mode,
    input  wire logic [rpqd_pkg::HANDLE_W-1:0]       first_handle,
    input  wire logic [rpqd_pkg::HANDLE_W-1:0]       last_handle,
    input  wire logic [rpqd_pkg::WID_W-1:0]          worker_id,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [rpqd_pkg::STATUS_W-1:0]       status,
    output logic      [rpqd_pkg::HANDLE_W-1:0]       handle_out
);

    import rpqd_pkg::*;

    localparam int IW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int NQW = $clog2(NUM_QUEUES + 1);
    localparam int NW  = (NQW > WCOUNT_W) ? NQW : WCOUNT_W;
    localparam int EW  = IW + IW + CW;
    localparam int SD  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW  = (SD > 1) ? $clog2(SD) : 1;

    state_t                state_reg, state_next;
    logic                  bind_mode_reg;
    logic [WCOUNT_W-1:0]   worker_count_reg;
    logic [QW-1:0]         q_reg, q_next;
    logic [HANDLE_W-1:0]   h_reg, h_next;
    logic [HANDLE_W-1:0]   last_reg, last_next;
    logic                  deq_bad_reg, deq_bad_next;
    logic                  ovf_reg, ovf_next;
    logic                  b_valid_reg, b_valid_next;
    logic [QW-1:0]         b_q_reg, b_q_next;
    logic [HANDLE_W-1:0]   b_h_reg, b_h_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [HANDLE_W-1:0]   res_handle_reg, res_handle_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [HANDLE_W-1:0]   out_handle_reg, out_handle_next;

    logic                  in_xfer;
    logic [NW-1:0]         wc_ext;
    logic [NW-1:0]         n_eff;
    logic [NW-1:0]         n_deal;
    logic [NW-1:0]         q_plus;

    logic [EW-1:0]         ptr_rd_data;
    logic [IW-1:0]         p_head;
    logic [IW-1:0]         p_tail;
    logic [CW-1:0]         p_count;
    logic [IW-1:0]         p_head_inc;
    logic [IW-1:0]         p_tail_inc;
    logic                  ptr_wr_en;
    logic [QW-1:0]         ptr_wr_addr;
    logic [EW-1:0]         ptr_wr_data;

    logic                  b_full;
    logic                  b_push;
    logic                  deq_empty;
    logic                  deq_pop;

    logic                  st_wr_en;
    logic [AW-1:0]         st_wr_addr;
    logic [HANDLE_BITS-1:0] st_wr_data;
    logic [AW-1:0]         st_rd_addr;
    logic [HANDLE_BITS-1:0] st_rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bind_mode_reg    <= 1'b0;
            worker_count_reg <= WCOUNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIND_MODE:    bind_mode_reg    <= cfg_data[0];
                CFG_WORKER_COUNT: worker_count_reg <= cfg_data[WCOUNT_W-1:0];
                default:          bind_mode_reg    <= bind_mode_reg;
            endcase
        end
    end

    // Number of queues in the deal: zero counts as one, large values saturate.
    always_comb
    begin
        wc_ext = NW'(worker_count_reg);
        if (worker_count_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (wc_ext > NW'(NUM_QUEUES))
        begin
            n_eff = NW'(NUM_QUEUES);
        end
        else
        begin
            n_eff = wc_ext;
        end
        n_deal = bind_mode_reg ? n_eff : NW'(1);
        q_plus = NW'(q_reg) + NW'(1);
    end

    // Pointer word fields as read (with bypass) for the queue in flight.
    assign p_head     = ptr_rd_data[EW-1 -: IW];
    assign p_tail     = ptr_rd_data[CW+IW-1 -: IW];
    assign p_count    = ptr_rd_data[CW-1:0];
    assign p_head_inc = (p_head == IW'(QUEUE_DEPTH - 1)) ? '0 : p_head + IW'(1);
    assign p_tail_inc = (p_tail == IW'(QUEUE_DEPTH - 1)) ? '0 : p_tail + IW'(1);

    assign b_full    = (p_count == CW'(QUEUE_DEPTH));
    assign b_push    = b_valid_reg && !b_full;
    assign deq_empty = deq_bad_reg || (p_count == '0);
    assign deq_pop   = (state_reg == S_DQ_PTR) && !deq_empty;

    // Push and pop never overlap, so one write port serves both.
    assign ptr_wr_en   = b_push || deq_pop;
    assign ptr_wr_addr = b_valid_reg ? b_q_reg : q_reg;
    assign ptr_wr_data = b_valid_reg ? {p_head, p_tail_inc, p_count + CW'(1)}
                                     : {p_head_inc, p_tail, p_count - CW'(1)};

    assign st_wr_en   = b_push;
    assign st_wr_addr = AW'(32'(b_q_reg) * 32'(QUEUE_DEPTH) + 32'(p_tail));
    assign st_wr_data = HANDLE_BITS'(b_h_reg);
    assign st_rd_addr = AW'(32'(q_reg) * 32'(QUEUE_DEPTH) + 32'(p_head));

    rpqd_ptr_table #(
        .ENTRIES   (NUM_QUEUES),
        .ADDR_BITS (QW),
        .DATA_BITS (EW)
    ) u_ptr_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (q_reg),
        .rd_data (ptr_rd_data),
        .wr_en   (ptr_wr_en),
        .wr_addr (ptr_wr_addr),
        .wr_data (ptr_wr_data)
    );

    rpqd_store_ram #(
        .DEPTH     (SD),
        .ADDR_BITS (AW),
        .DATA_BITS (HANDLE_BITS)
    ) u_store_ram (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (deq_pop),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        state_next      = state_reg;
        q_next          = q_reg;
        h_next          = h_reg;
        last_next       = last_reg;
        deq_bad_next    = deq_bad_reg;
        ovf_next        = ovf_reg;
        b_valid_next    = 1'b0;
        b_q_next        = b_q_reg;
        b_h_next        = b_h_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (b_valid_reg && b_full)
        begin
            ovf_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    ovf_next     = 1'b0;
                    h_next       = first_handle;
                    last_next    = last_handle;
                    q_next       = (mode == MODE_DEQ && bind_mode_reg) ? QW'(worker_id) : '0;
                    deq_bad_next = bind_mode_reg && (32'(worker_id) >= 32'(NUM_QUEUES));
                    if (mode == MODE_DEQ)
                    begin
                        state_next = S_DQ_RD;
                    end
                    else if (first_handle > last_handle)
                    begin
                        res_status_next = ST_REVERSED;
                        res_handle_next = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ENQ;
                    end
                end
            end
            S_ENQ:
            begin
                // Issue the pointer read for this handle; the push completes next cycle.
                b_valid_next = 1'b1;
                b_q_next     = q_reg;
                b_h_next     = h_reg;
                if (h_reg == last_reg)
                begin
                    state_next = S_ENQ_END;
                end
                else
                begin
                    h_next = h_reg + HANDLE_W'(1);
                    q_next = (q_plus >= n_deal) ? '0 : QW'(q_plus);
                end
            end
            S_ENQ_END:
            begin
                res_status_next = (ovf_reg || (b_valid_reg && b_full)) ? ST_OVERFLOW : ST_OK;
                res_handle_next = '0;
                state_next      = S_DONE;
            end
            S_DQ_RD:
            begin
                state_next = S_DQ_PTR;
            end
            S_DQ_PTR:
            begin
                if (deq_empty)
                begin
                    res_status_next = ST_EMPTY;
                    res_handle_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_DQ_DATA;
                end
            end
            S_DQ_DATA:
            begin
                res_status_next = ST_OK;
                res_handle_next = HANDLE_W'(st_rd_data);
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            deq_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            ovf_reg       <= ovf_next;
            deq_bad_reg   <= deq_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        h_reg          <= h_next;
        last_reg       <= last_next;
        b_q_reg        <= b_q_next;
        b_h_reg        <= b_h_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign handle_out = out_handle_reg;

    // A push in flight only exists while an enqueue is being dealt out.
    a_push_in_enq: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (state_reg == S_ENQ || state_reg == S_ENQ_END))
        else $error("push stage active outside an enqueue");

    // Every push stage follows a pointer read issued in the enqueue state.
    a_push_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> $past(state_reg == S_ENQ))
        else $error("push stage without a preceding pointer read");

    // A pointer write never raises a fill count past the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_wr_en |-> (ptr_wr_data[CW-1:0] <= CW'(QUEUE_DEPTH)))
        else $error("queue fill count beyond depth");

    // A finished result waits while the output register is held.
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result overwrote a stalled output");

endmodule

`default_nettype wire
